[rtl/grid_cell_slot_table_assert.svh]
// ----------------------------------------------------------------------------
// grid_cell_slot_table assertion macros
// Shared assertion macros for the grid cell slot table. The checks are
// compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_SLOT_TABLE_ASSERT_SVH
`define GRID_CELL_SLOT_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and disabled in reset.
`define GCST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk and disabled in reset.
`define GCST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GCST_ASSERT_IMP(lbl, ante, cons, msg)
`define GCST_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/gcst_pkg.sv]
// ----------------------------------------------------------------------------
// gcst_pkg
// Types, codes, widths and helper functions shared by the grid cell slot
// table controller, datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcst_pkg;

  // Default sizes of the table.
  localparam int MAX_CELLS_DEF    = 1024;
  localparam int CAP_OBJECT3D_DEF = 100;
  localparam int CAP_OBJECT2D_DEF = 20;
  localparam int CAP_LIGHT_DEF    = 4;
  localparam int CAP_PARTICLE_DEF = 4;

  // Field widths.
  localparam int ID_W       = 12;
  localparam int POS_W      = 14;
  localparam int KIND_W     = 2;
  localparam int MAPW_W     = 11;
  localparam int STAT_W     = 2;
  localparam int SLOT_W     = 7;
  localparam int CELLREP_W  = 10;
  localparam int SCOORD_W   = 7;
  localparam int CPR_W      = MAPW_W - 2;
  localparam int PROD_W     = 16;
  localparam int CELL_W     = 17;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MAPW_W-1:0]    MAP_WIDTH_RST   = 11'd256;
  localparam logic [CELLREP_W-1:0] CELL_REPORT_MAX = 10'd1023;

  // Configuration register word index (paddr bit 2).
  localparam logic REG_MAP_WIDTH = 1'b0;

  typedef enum logic {
    FUNC_ADD,
    FUNC_DEL
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_OBJ3D,
    KIND_OBJ2D,
    KIND_LIGHT,
    KIND_PARTICLE
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_RANGE = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_RANGE,
    ST_CNT,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic mul;
    logic sum;
    logic range;
    logic add;
    logic scan_clear;
    logic scan_step;
    logic scan_fin;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic oor;
    logic del;
    logic scan_last;
    logic out_free;
  } status_t;

  // Address width for a memory of n entries, at least one bit.
  function automatic int addr_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // floor(v / 192): drop six bits, then divide by three as (u * 171) >> 9,
  // which is exact for every eight-bit u.
  function automatic logic [SCOORD_W-1:0] div192(input logic [POS_W-1:0] v);
    logic [15:0] p;
    p = 16'(v[POS_W-1:6]) * 16'd171;
    return p[15:9];
  endfunction

endpackage

`default_nettype wire

[rtl/gcst_ctrl.sv]
// ----------------------------------------------------------------------------
// gcst_ctrl
// Controller of the grid cell slot table: clears the fill counts after
// reset, then steps each transaction through cell calculation, count
// lookup, add or delete scan, and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcst_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  gcst_pkg::status_t  st,
  output gcst_pkg::cmd_t     cmd
);

  gcst_pkg::state_t state_r;
  gcst_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gcst_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gcst_pkg::ST_CLEAR: begin
        if (st.clr_last) state_nxt = gcst_pkg::ST_IDLE;
      end
      gcst_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = gcst_pkg::ST_MUL;
      end
      gcst_pkg::ST_MUL:   state_nxt = gcst_pkg::ST_SUM;
      gcst_pkg::ST_SUM:   state_nxt = gcst_pkg::ST_RANGE;
      gcst_pkg::ST_RANGE: begin
        state_nxt = st.oor ? gcst_pkg::ST_DONE : gcst_pkg::ST_CNT;
      end
      gcst_pkg::ST_CNT: begin
        state_nxt = st.del ? gcst_pkg::ST_SCAN : gcst_pkg::ST_DONE;
      end
      gcst_pkg::ST_SCAN: begin
        if (st.scan_last) state_nxt = gcst_pkg::ST_DONE;
      end
      gcst_pkg::ST_DONE: begin
        if (st.out_free) state_nxt = gcst_pkg::ST_IDLE;
      end
      default: state_nxt = gcst_pkg::ST_CLEAR;
    endcase
  end

  // Commands for the current state.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      gcst_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      gcst_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      gcst_pkg::ST_MUL:   cmd.mul   = 1'b1;
      gcst_pkg::ST_SUM:   cmd.sum   = 1'b1;
      gcst_pkg::ST_RANGE: cmd.range = 1'b1;
      gcst_pkg::ST_CNT: begin
        cmd.add        = !st.del;
        cmd.scan_clear = st.del;
      end
      gcst_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.scan_fin  = st.scan_last;
      end
      gcst_pkg::ST_DONE: cmd.emit = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/gcst_dp.sv]
// ----------------------------------------------------------------------------
// gcst_dp
// Datapath of the grid cell slot table: cell index arithmetic, per-cell
// fill counts, the four slot memories, the delete scan with shift-down,
// and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "grid_cell_slot_table_assert.svh"

module gcst_dp #(
  parameter int MAX_CELLS    = gcst_pkg::MAX_CELLS_DEF,
  parameter int CAP_OBJECT3D = gcst_pkg::CAP_OBJECT3D_DEF,
  parameter int CAP_OBJECT2D = gcst_pkg::CAP_OBJECT2D_DEF,
  parameter int CAP_LIGHT    = gcst_pkg::CAP_LIGHT_DEF,
  parameter int CAP_PARTICLE = gcst_pkg::CAP_PARTICLE_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  gcst_pkg::cmd_t                       cmd,
  output gcst_pkg::status_t                    st,
  input  wire [gcst_pkg::MAPW_W-1:0]           map_width,
  input  wire                                  in_func,
  input  wire [gcst_pkg::KIND_W-1:0]           in_kind,
  input  wire [gcst_pkg::ID_W-1:0]             in_id,
  input  wire [gcst_pkg::POS_W-1:0]            in_pos_x,
  input  wire [gcst_pkg::POS_W-1:0]            in_pos_y,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [gcst_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int CAP_A   = (CAP_OBJECT3D > CAP_OBJECT2D) ? CAP_OBJECT3D : CAP_OBJECT2D;
  localparam int CAP_B   = (CAP_LIGHT > CAP_PARTICLE) ? CAP_LIGHT : CAP_PARTICLE;
  localparam int CAP_MAX = (CAP_A > CAP_B) ? CAP_A : CAP_B;
  localparam int IW      = $clog2(CAP_MAX + 1);
  localparam int CIW     = gcst_pkg::addr_w(MAX_CELLS);
  localparam int ABW     = gcst_pkg::addr_w(MAX_CELLS * CAP_MAX);
  localparam int NKIND   = 4;

  localparam logic [gcst_pkg::CELL_W-1:0] CELL_LIMIT = gcst_pkg::CELL_W'(MAX_CELLS);
  localparam logic [gcst_pkg::CELL_W-1:0] CELL_SAT   =
    gcst_pkg::CELL_W'(gcst_pkg::CELL_REPORT_MAX);
  localparam logic [CIW-1:0] CLR_LAST = CIW'(MAX_CELLS - 1);

  // Request registers.
  gcst_pkg::func_t                  func_r;
  gcst_pkg::kind_t                  kind_r;
  logic [gcst_pkg::ID_W-1:0]        id_r;
  logic [gcst_pkg::POS_W-1:0]       px_r;
  logic [gcst_pkg::POS_W-1:0]       py_r;

  // Cell arithmetic registers.
  logic [gcst_pkg::SCOORD_W-1:0]    sx_r;
  logic [gcst_pkg::PROD_W-1:0]      prod_r;
  logic [gcst_pkg::CELL_W-1:0]      cell_r;
  logic [ABW-1:0]                   base_r;

  // Scan, result, clear and output registers.
  logic [IW-1:0]                    idx_r;
  logic                             found_r;
  logic [IW-1:0]                    fidx_r;
  gcst_pkg::stat_t                  res_status_r;
  logic [gcst_pkg::SLOT_W-1:0]      res_slot_r;
  logic [CIW-1:0]                   clr_idx_r;
  logic                             out_tvalid_r;
  logic [gcst_pkg::OUT_DATA_W-1:0]  out_tdata_r;

  // Combinational signals.
  logic [gcst_pkg::SCOORD_W-1:0]    sx;
  logic [gcst_pkg::SCOORD_W-1:0]    sy;
  logic [gcst_pkg::CPR_W-1:0]       cpr;
  logic [CIW-1:0]                   cell_idx;
  logic [IW-1:0]                    cap_sel;
  logic [IW-1:0]                    cnt_sel;
  logic [gcst_pkg::ID_W-1:0]        slot_sel;
  logic                             oor;
  logic                             add_full;
  logic                             scan_last;
  logic                             proc;
  logic                             match;
  logic                             found_now;
  logic [IW-1:0]                    fidx_now;
  logic                             shift_we;
  logic                             slot_we_any;
  logic [ABW-1:0]                   slot_raddr;
  logic [ABW-1:0]                   slot_waddr;
  logic [gcst_pkg::ID_W-1:0]        slot_wdata;
  logic                             cnt_we_any;
  logic [CIW-1:0]                   cnt_waddr;
  logic [IW-1:0]                    cnt_wdata;
  logic [gcst_pkg::CELLREP_W-1:0]   cell_rep;
  logic [gcst_pkg::ID_W-1:0]        slot_rd [NKIND];
  logic [IW-1:0]                    cnt_rd  [NKIND];

  // Cell coordinates and cells per row.
  assign sx       = gcst_pkg::div192(px_r);
  assign sy       = gcst_pkg::div192(py_r);
  assign cpr      = map_width[gcst_pkg::MAPW_W-1:2];
  assign cell_idx = cell_r[CIW-1:0];
  assign oor      = (cell_r >= CELL_LIMIT);

  // Capacity of the selected list.
  always_comb begin
    case (kind_r)
      gcst_pkg::KIND_OBJ3D: cap_sel = IW'(CAP_OBJECT3D);
      gcst_pkg::KIND_OBJ2D: cap_sel = IW'(CAP_OBJECT2D);
      gcst_pkg::KIND_LIGHT: cap_sel = IW'(CAP_LIGHT);
      default:              cap_sel = IW'(CAP_PARTICLE);
    endcase
  end

  assign cnt_sel  = cnt_rd[kind_r];
  assign slot_sel = slot_rd[kind_r];
  assign add_full = (cnt_sel >= cap_sel);

  // Delete scan: slot idx_r is read while slot idx_r-1 is compared or moved
  // down into slot idx_r-2 once the match has been seen.
  assign scan_last = (idx_r == cnt_sel);
  assign proc      = cmd.scan_step && (idx_r != '0);
  assign match     = proc && !found_r && (slot_sel == id_r);
  assign shift_we  = proc && found_r;
  assign found_now = found_r || match;
  assign fidx_now  = match ? (idx_r - 1'b1) : fidx_r;

  // Slot memory write and read ports.
  assign slot_raddr  = base_r + ABW'(idx_r);
  assign slot_waddr  = cmd.add ? (base_r + ABW'(cnt_sel))
                               : (base_r + ABW'(idx_r) - ABW'(2));
  assign slot_wdata  = cmd.add ? id_r : slot_sel;
  assign slot_we_any = (cmd.add && !add_full) || shift_we;

  // Fill count write port.
  assign cnt_we_any = cmd.clr_step || (cmd.add && !add_full) || (cmd.scan_fin && found_now);
  assign cnt_waddr  = cmd.clr_step ? clr_idx_r : cell_idx;
  always_comb begin
    if (cmd.clr_step) begin
      cnt_wdata = '0;
    end else if (cmd.add) begin
      cnt_wdata = cnt_sel + 1'b1;
    end else begin
      cnt_wdata = cnt_sel - 1'b1;
    end
  end

  // One fill count memory and one slot memory per list kind.
  for (genvar gk = 0; gk < NKIND; gk++) begin : g_list
    localparam int CAP_K = (gk == 0) ? CAP_OBJECT3D :
                           (gk == 1) ? CAP_OBJECT2D :
                           (gk == 2) ? CAP_LIGHT : CAP_PARTICLE;
    localparam int CW    = $clog2(CAP_K + 1);
    localparam int AW    = gcst_pkg::addr_w(MAX_CELLS * CAP_K);

    logic [gcst_pkg::ID_W-1:0] slot_mem [MAX_CELLS * CAP_K];
    logic [CW-1:0]             cnt_mem  [MAX_CELLS];
    logic [gcst_pkg::ID_W-1:0] slot_q_r;
    logic [CW-1:0]             cnt_q_r;
    logic                      sel;

    assign sel = (kind_r == gcst_pkg::kind_t'(gk));

    // Slot memory, registered read.
    always_ff @(posedge clk) begin
      if (slot_we_any && sel) begin
        slot_mem[slot_waddr[AW-1:0]] <= slot_wdata;
      end
      slot_q_r <= slot_mem[slot_raddr[AW-1:0]];
    end

    // Fill count memory, registered read; cleared by the sweep after reset.
    always_ff @(posedge clk) begin
      if (cnt_we_any && (sel || cmd.clr_step)) begin
        cnt_mem[cnt_waddr] <= cnt_wdata[CW-1:0];
      end
      cnt_q_r <= cnt_mem[cell_idx];
    end

    assign slot_rd[gk] = slot_q_r;
    assign cnt_rd[gk]  = IW'(cnt_q_r);
  end

  // Request capture and cell arithmetic pipeline.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= gcst_pkg::func_t'(in_func);
      kind_r <= gcst_pkg::kind_t'(in_kind);
      id_r   <= in_id;
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
    end
    if (cmd.mul) begin
      prod_r <= gcst_pkg::PROD_W'(sy) * gcst_pkg::PROD_W'(cpr);
      sx_r   <= sx;
    end
    if (cmd.sum) begin
      cell_r <= gcst_pkg::CELL_W'(prod_r) + gcst_pkg::CELL_W'(sx_r);
    end
    if (cmd.range) begin
      base_r <= ABW'(cell_idx) * ABW'(cap_sel);
    end
  end

  // Scan bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      if (match) begin
        found_r <= 1'b1;
        fidx_r  <= idx_r - 1'b1;
      end
    end
  end

  // Result of the current transaction.
  always_ff @(posedge clk) begin
    if (cmd.range && oor) begin
      res_status_r <= gcst_pkg::STAT_RANGE;
      res_slot_r   <= '0;
    end else if (cmd.add) begin
      res_status_r <= add_full ? gcst_pkg::STAT_MISS : gcst_pkg::STAT_DONE;
      res_slot_r   <= add_full ? '0 : gcst_pkg::SLOT_W'(cnt_sel);
    end else if (cmd.scan_fin) begin
      res_status_r <= found_now ? gcst_pkg::STAT_DONE : gcst_pkg::STAT_MISS;
      res_slot_r   <= found_now ? gcst_pkg::SLOT_W'(fidx_now) : '0;
    end
  end

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_step) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // Reported cell index, saturated.
  always_comb begin
    if (res_status_r == gcst_pkg::STAT_RANGE || cell_r > CELL_SAT) begin
      cell_rep = gcst_pkg::CELL_REPORT_MAX;
    end else begin
      cell_rep = cell_r[gcst_pkg::CELLREP_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= {5'd0, cell_rep, res_slot_r, res_status_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Status to the controller.
  assign st.clr_last  = (clr_idx_r == CLR_LAST);
  assign st.oor       = oor;
  assign st.del       = (func_r == gcst_pkg::FUNC_DEL);
  assign st.scan_last = scan_last;
  assign st.out_free  = !out_tvalid_r || out_tready;

  // A new result never overwrites one that is still waiting.
  `GCST_ASSERT_IMP(a_emit_free, cmd.emit, !out_tvalid_r || out_tready, "result overwritten")
  // A list count never grows past the capacity of its list.
  `GCST_ASSERT_IMP(a_cnt_cap, cnt_we_any && !cmd.clr_step, cnt_wdata <= cap_sel, "count over cap")
  // Once a match is seen, the slot being moved lies past it.
  `GCST_ASSERT_IMP(a_shift_after, cmd.scan_step && found_r, fidx_r < idx_r, "shift before match")
  // A request is never answered in the cycle after it is taken.
  `GCST_ASSERT_NXT(a_no_early, cmd.accept, !cmd.emit, "result too early")

endmodule

`default_nettype wire

[rtl/grid_cell_slot_table.sv]
// ----------------------------------------------------------------------------
// grid_cell_slot_table
// Spatial grid bucket list. Each request adds an object id to, or deletes it
// from, one of four per-cell lists (3D objects, 2D objects, lights, particle
// systems) of the cell that holds the given position, and returns exactly
// one result. After reset the block sweeps the per-cell fill counts with
// in_tready low; configuration writes are taken during the sweep. An add
// request steps through cell calculation, range check, fill count lookup
// and result hand-off; an out-of-range request skips the fill count lookup.
// A delete then scans the addressed list, reading one slot per cycle from
// the list's slot memory (one read port, one write port) and moving later
// slots down as it goes.
// A finished result waits in the output register while the next request is
// accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_cell_slot_table #(
  parameter int MAX_CELLS    = gcst_pkg::MAX_CELLS_DEF,
  parameter int CAP_OBJECT3D = gcst_pkg::CAP_OBJECT3D_DEF,
  parameter int CAP_OBJECT2D = gcst_pkg::CAP_OBJECT2D_DEF,
  parameter int CAP_LIGHT    = gcst_pkg::CAP_LIGHT_DEF,
  parameter int CAP_PARTICLE = gcst_pkg::CAP_PARTICLE_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // Request channel.
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // func[0], object_id[12:1], pos_x[26:13], pos_y[40:27], zero[47:41]
  input  wire [gcst_pkg::IN_DATA_W-1:0]      in_tdata,
  // list_kind[1:0]
  input  wire [gcst_pkg::KIND_W-1:0]         in_tuser,
  // Result channel.
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // status[1:0], slot_index[8:2], cell_index[18:9], zero[23:19]
  output logic [gcst_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration port.
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire [gcst_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire [gcst_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [gcst_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  logic [gcst_pkg::MAPW_W-1:0] map_width_r;
  logic                        cfg_wr;
  gcst_pkg::cmd_t              cmd;
  gcst_pkg::status_t           st;

  // Configuration register, written on the access cycle of a write.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r <= gcst_pkg::MAP_WIDTH_RST;
    end else if (cfg_wr && (cfg_paddr[2] == gcst_pkg::REG_MAP_WIDTH)) begin
      map_width_r <= cfg_pwdata[gcst_pkg::MAPW_W-1:0];
    end
  end

  // Register read-back.
  always_comb begin
    if (cfg_paddr[2] == gcst_pkg::REG_MAP_WIDTH) begin
      cfg_prdata = gcst_pkg::CFG_DATA_W'(map_width_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  gcst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  gcst_dp #(
    .MAX_CELLS    (MAX_CELLS),
    .CAP_OBJECT3D (CAP_OBJECT3D),
    .CAP_OBJECT2D (CAP_OBJECT2D),
    .CAP_LIGHT    (CAP_LIGHT),
    .CAP_PARTICLE (CAP_PARTICLE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .map_width  (map_width_r),
    .in_func    (in_tdata[0]),
    .in_kind    (in_tuser),
    .in_id      (in_tdata[12:1]),
    .in_pos_x   (in_tdata[26:13]),
    .in_pos_y   (in_tdata[40:27]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[bench/grid_cell_slot_table_tb.sv]
// ----------------------------------------------------------------------------
// grid_cell_slot_table_tb
// Self-checking bench for the grid cell slot table. Requests go in on the
// input stream, and a mirror of the per-cell slot lists predicts every result.
// Directed tests cover position extremes, full lists, duplicate ids and map
// width settings. A random phase follows with hot cells, noise requests, and
// idle bursts on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_cell_slot_table_tb;
  import gcst_pkg::*;

  localparam int TABLE_CELLS   = MAX_CELLS_DEF;
  localparam int SLOT_STRIDE   = 128;
  localparam int CELL_SPAN_FIX = 192;
  localparam int POS_MAX       = 16383;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 120;

  // Byte addresses of the register words. The second word has no register.
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_MAP_WIDTH = {REG_MAP_WIDTH, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_SPARE     = {~REG_MAP_WIDTH, 2'b00};

  typedef struct packed {
    stat_t                status;
    logic [SLOT_W-1:0]    slot;
    logic [CELLREP_W-1:0] cell_idx;
  } slot_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // func[0], object_id[12:1], pos_x[26:13], pos_y[40:27]
  logic [KIND_W-1:0]     in_tuser;   // list_kind[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;  // status[1:0], slot_index[8:2], cell_index[18:9]

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Mirror of the slot lists: entry {kind, cell, slot}, valid bit on top.
  bit [ID_W:0]       slot_mirror [4*TABLE_CELLS*SLOT_STRIDE];
  logic [MAPW_W-1:0] cur_map_width;
  slot_result_t      pending_results[$];
  int                mismatch_count = 0;
  bit                quiet = 1'b0;
  int                stall_left = 0;
  int                hot_sx [4];
  int                hot_sy [4];

  grid_cell_slot_table u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Mirror of the table.
  // ---------------------------------------------------------------------------
  function automatic int list_cap(input kind_t k);
    case (k)
      KIND_OBJ3D: return CAP_OBJECT3D_DEF;
      KIND_OBJ2D: return CAP_OBJECT2D_DEF;
      KIND_LIGHT: return CAP_LIGHT_DEF;
      default:    return CAP_PARTICLE_DEF;
    endcase
  endfunction

  function automatic int slot_base(input kind_t k, input int cell_no);
    return (int'(k) * TABLE_CELLS + cell_no) * SLOT_STRIDE;
  endfunction

  // Cell index from a fixed-point position and the current row length.
  function automatic int grid_cell(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
    return (int'(py) / CELL_SPAN_FIX) * int'(cur_map_width >> 2) + int'(px) / CELL_SPAN_FIX;
  endfunction

  // Valid slots always form a prefix of the list, so count until the first gap.
  function automatic int list_fill(input kind_t k, input int cell_no);
    int n;
    int base;
    n = 0;
    if (cell_no >= TABLE_CELLS) return 0;
    base = slot_base(k, cell_no);
    while (n < list_cap(k) && slot_mirror[base + n][ID_W]) n++;
    return n;
  endfunction

  function automatic logic [ID_W-1:0] stored_id(input kind_t k, input int cell_no, input int i);
    return slot_mirror[slot_base(k, cell_no) + i][ID_W-1:0];
  endfunction

  // Apply one add or delete to the mirror and return the result it must give.
  function automatic slot_result_t predict_slot_op(input func_t f, input kind_t k,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [POS_W-1:0] px,
                                                   input logic [POS_W-1:0] py);
    slot_result_t r;
    int cell_no;
    int cap;
    int base;
    int hit;
    int i;
    r.status = STAT_DONE;
    r.slot   = '0;
    cell_no  = grid_cell(px, py);
    if (cell_no >= TABLE_CELLS) begin
      r.status   = STAT_RANGE;
      r.cell_idx = CELL_REPORT_MAX;
      return r;
    end
    r.cell_idx = (cell_no > int'(CELL_REPORT_MAX)) ? CELL_REPORT_MAX : CELLREP_W'(cell_no);
    cap    = list_cap(k);
    base   = slot_base(k, cell_no);
    hit    = -1;
    if (f == FUNC_ADD) begin
      for (i = 0; i < cap && hit < 0; i++)
        if (!slot_mirror[base + i][ID_W]) hit = i;
      if (hit >= 0) slot_mirror[base + hit] = {1'b1, id};
    end else begin
      for (i = 0; i < cap && hit < 0; i++)
        if (slot_mirror[base + i] == {1'b1, id}) hit = i;
      if (hit >= 0) begin
        for (i = hit; i < cap - 1; i++) slot_mirror[base + i] = slot_mirror[base + i + 1];
        slot_mirror[base + cap - 1] = '0;
      end
    end
    if (hit < 0) r.status = STAT_MISS;
    else r.slot = SLOT_W'(hit);
    return r;
  endfunction

  // A random position inside cell column or row s.
  function automatic logic [POS_W-1:0] coord_in(input int s);
    int top;
    top = POS_MAX - s * CELL_SPAN_FIX;
    if (top > CELL_SPAN_FIX - 1) top = CELL_SPAN_FIX - 1;
    return POS_W'(s * CELL_SPAN_FIX + $urandom_range(0, top));
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and result checking.
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Each result transaction is compared with the oldest outstanding prediction.
  always @(posedge clk) begin : check_results
    slot_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result 0x%06h", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.status)
          flag_error($sformatf("status %0d, expected %0d (cell %0d)",
                               out_tdata[1:0], want.status, want.cell_idx));
        if (out_tdata[8:2] !== want.slot)
          flag_error($sformatf("slot_index %0d, expected %0d (cell %0d)",
                               out_tdata[8:2], want.slot, want.cell_idx));
        if (out_tdata[18:9] !== want.cell_idx)
          flag_error($sformatf("cell_index %0d, expected %0d", out_tdata[18:9],
                               want.cell_idx));
      end
    end
  end

  // Result back-pressure: random stall bursts.
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  // Offer one request and predict its result once the transaction completes.
  // tvalid stays high afterwards so back-to-back requests need no idle cycle.
  task automatic send_request(input func_t f, input kind_t k, input logic [ID_W-1:0] id,
                              input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, py, px, id, f};
    in_tuser  <= k;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_slot_op(f, k, id, px, py));
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic wait_for_results(input int settle);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr[2] == REG_MAP_WIDTH) cur_map_width = value[MAPW_W-1:0];
  endtask

  // Choose four in-range cells for the current map width.
  task automatic pick_hot_cells();
    int cpr;
    int lim;
    int c;
    cpr = int'(cur_map_width >> 2);
    for (c = 0; c < 4; c++) begin
      if (cpr == 0) begin
        hot_sy[c] = $urandom_range(0, 85);
        hot_sx[c] = $urandom_range(0, 85);
      end else begin
        lim = (TABLE_CELLS - 1) / cpr;
        if (lim > 85) lim = 85;
        hot_sy[c] = $urandom_range(0, lim);
        lim = TABLE_CELLS - 1 - hot_sy[c] * cpr;
        if (lim > 85) lim = 85;
        hot_sx[c] = $urandom_range(0, lim);
      end
    end
  endtask

  // Mostly adds and deletes on hot cells, deletes mostly naming a stored id;
  // the rest is noise over the whole field range.
  task automatic send_random_request();
    func_t            f;
    kind_t            k;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    int               c;
    int               n;
    k  = kind_t'($urandom_range(0, 3));
    id = ID_W'($urandom_range(0, 4095));
    if ($urandom_range(0, 99) < 15) begin
      f  = func_t'($urandom_range(0, 1));
      px = POS_W'($urandom_range(0, POS_MAX));
      py = POS_W'($urandom_range(0, POS_MAX));
    end else begin
      c  = $urandom_range(0, 3);
      px = coord_in(hot_sx[c]);
      py = coord_in(hot_sy[c]);
      f  = ($urandom_range(0, 99) < 55) ? FUNC_ADD : FUNC_DEL;
      n  = list_fill(k, grid_cell(px, py));
      if (n > 0 && $urandom_range(0, 4) != 0 && (f == FUNC_DEL || $urandom_range(0, 3) == 0))
        id = stored_id(k, grid_cell(px, py), $urandom_range(0, n - 1));
    end
    send_request(f, k, id, px, py);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // Position and id extremes at the reset map width (64 cells per row).
  task automatic test_cell_extremes();
    send_request(FUNC_ADD, KIND_OBJ3D, 12'd0, 14'd0, 14'd0);
    send_request(FUNC_ADD, KIND_OBJ3D, 12'hFFF, 14'd0, 14'd0);
    send_request(FUNC_ADD, KIND_OBJ2D, 12'hFFF, 14'd191, 14'd191);
    send_request(FUNC_ADD, KIND_PARTICLE, 12'hAAA, 14'h3FFF, 14'd0);
    send_request(FUNC_ADD, KIND_LIGHT, 12'h555, 14'd0, 14'h3FFF);
    send_request(FUNC_DEL, KIND_OBJ3D, 12'hFFF, 14'h3FFF, 14'h3FFF);
    send_request(FUNC_DEL, KIND_OBJ3D, 12'd0, 14'd0, 14'd0);
    send_request(FUNC_DEL, KIND_OBJ3D, 12'd0, 14'd0, 14'd0);
    send_request(FUNC_DEL, KIND_OBJ3D, 12'hFFF, 14'd5, 14'd9);
    send_request(FUNC_ADD, KIND_LIGHT, 12'h555, 14'd192, 14'd2880);
  endtask

  // A light list filled past capacity, duplicate ids, and deletes that shift.
  task automatic test_list_full_and_duplicates();
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    px = coord_in(5);
    py = coord_in(2);
    send_request(FUNC_ADD, KIND_LIGHT, 12'h123, px, py);
    send_request(FUNC_ADD, KIND_LIGHT, 12'h123, px, py);
    send_request(FUNC_ADD, KIND_LIGHT, 12'h456, px, py);
    send_request(FUNC_ADD, KIND_LIGHT, 12'h789, px, py);
    send_request(FUNC_ADD, KIND_LIGHT, 12'hABC, px, py);
    send_request(FUNC_DEL, KIND_LIGHT, 12'h123, px, py);
    send_request(FUNC_DEL, KIND_LIGHT, 12'h123, px, py);
    send_request(FUNC_DEL, KIND_LIGHT, 12'h789, px, py);
    send_request(FUNC_DEL, KIND_LIGHT, 12'h789, px, py);
  endtask

  // Map width extremes, a narrow map, wide values truncated to the register,
  // and a write to the unused word.
  task automatic test_map_width_register();
    wait_for_results(SETTLE_CYCLES);
    write_register(CFG_ADDR_MAP_WIDTH, 32'hFFFF_FFFF);
    send_request(FUNC_ADD, KIND_OBJ3D, 12'h001, coord_in(0), coord_in(2));
    send_request(FUNC_ADD, KIND_OBJ3D, 12'h002, coord_in(1), coord_in(2));
    send_request(FUNC_ADD, KIND_OBJ3D, 12'h003, coord_in(2), coord_in(2));
    wait_for_results(SETTLE_CYCLES);
    write_register(CFG_ADDR_MAP_WIDTH, 32'd0);
    send_request(FUNC_ADD, KIND_PARTICLE, 12'h7FF, 14'h3FFF, 14'h3FFF);
    wait_for_results(SETTLE_CYCLES);
    write_register(CFG_ADDR_SPARE, 32'd1024);
    send_request(FUNC_ADD, KIND_OBJ2D, 12'h800, coord_in(3), coord_in(40));
    wait_for_results(SETTLE_CYCLES);
    write_register(CFG_ADDR_MAP_WIDTH, 32'h0000_F804);
    send_request(FUNC_DEL, KIND_PARTICLE, 12'h7FF, coord_in(85), coord_in(85));
    wait_for_results(SETTLE_CYCLES);
    write_register(CFG_ADDR_MAP_WIDTH, 32'd1024);
    send_request(FUNC_ADD, KIND_LIGHT, 12'h0F0, coord_in(85), coord_in(3));
    send_request(FUNC_ADD, KIND_LIGHT, 12'h0F0, coord_in(0), coord_in(4));
  endtask

  // Fill one 3D list and one 2D list to capacity, then delete from them.
  task automatic test_list_capacity();
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    kind_t            k;
    int               cap;
    int               n;
    int               pass;
    int               i;
    wait_for_results(SETTLE_CYCLES);
    write_register(CFG_ADDR_MAP_WIDTH, 32'd256);
    for (pass = 0; pass < 2; pass++) begin
      k   = (pass == 0) ? KIND_OBJ3D : KIND_OBJ2D;
      cap = list_cap(k);
      px  = coord_in($urandom_range(0, 63));
      py  = coord_in($urandom_range(0, 15));
      for (i = 0; i <= cap; i++)
        send_request(FUNC_ADD, k, ID_W'($urandom_range(0, 4095)), px, py);
      // The last slot first, then stored ids at random positions.
      send_request(FUNC_DEL, k, stored_id(k, grid_cell(px, py), cap - 1), px, py);
      for (i = 0; i < ((pass == 0) ? 14 : 4); i++) begin
        n = list_fill(k, grid_cell(px, py));
        send_request(FUNC_DEL, k, stored_id(k, grid_cell(px, py), $urandom_range(0, n - 1)),
                     px, py);
      end
      send_request(FUNC_DEL, k, ID_W'($urandom_range(0, 4095)), px, py);
    end
  endtask

  // Random traffic over several map widths; the last phase runs without idling.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] w;
    int                    p;
    for (p = 0; p < 6; p++) begin
      wait_for_results(SETTLE_CYCLES);
      case (p)
        0:       w = 32'd256;
        1:       w = 32'd2047;
        2:       w = 32'd0;
        3:       w = 32'd1024;
        4:       w = 32'd4;
        default: w = $urandom_range(5, 1023);
      endcase
      quiet = (p == 5);
      write_register(CFG_ADDR_MAP_WIDTH, w);
      pick_hot_cells();
      repeat (50) send_random_request();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    cur_map_width = MAP_WIDTH_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_cell_extremes();
    test_list_full_and_duplicates();
    test_map_width_register();
    test_list_capacity();
    test_random_traffic();
    wait_for_results(END_CYCLES);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
